>>> rtl/core/cdad_pkg.sv
// Package with the types, constants and calendar functions of the date adder.
`default_nettype none
package cdad_pkg;

   localparam int unsigned DayWidth   = 5;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 7;
   localparam int unsigned CentWidth  = 5;
   localparam int unsigned OrdWidth   = 9;
   localparam int unsigned AddWidth   = 16;
   localparam int unsigned PcWidth    = 3;

   localparam logic [AddWidth-1:0]   DefaultDays = 16'd7168;
   localparam logic [YearWidth-1:0]  LastYy      = 7'd99;
   localparam logic [YearWidth-1:0]  YyWrap      = 7'd100;
   localparam logic [CentWidth-1:0]  Cent19      = 5'd19;
   localparam logic [CentWidth-1:0]  Cent20      = 5'd20;
   localparam logic [CentWidth-1:0]  Cent21      = 5'd21;
   localparam logic [MonthWidth-1:0] LastMonth   = 4'd12;
   localparam logic [MonthWidth-1:0] February    = 4'd2;
   localparam logic [OrdWidth-1:0]   LeapLen     = 9'd366;
   localparam logic [OrdWidth-1:0]   PlainLen    = 9'd365;

   typedef enum logic [2:0] {
      OP_IDLE   = 3'd0,
      OP_LOAD   = 3'd1,
      OP_FIT    = 3'd2,
      OP_ZERO   = 3'd3,
      OP_SETLEN = 3'd4,
      OP_YEAR   = 3'd5,
      OP_MONTH  = 3'd6,
      OP_DONE   = 3'd7
   } op_type;

   localparam logic [PcWidth-1:0] StepIdle   = 3'd0;
   localparam logic [PcWidth-1:0] StepLoad   = 3'd1;
   localparam logic [PcWidth-1:0] StepFit    = 3'd2;
   localparam logic [PcWidth-1:0] StepZero   = 3'd3;
   localparam logic [PcWidth-1:0] StepSetlen = 3'd4;
   localparam logic [PcWidth-1:0] StepYear   = 3'd5;
   localparam logic [PcWidth-1:0] StepMonth  = 3'd6;
   localparam logic [PcWidth-1:0] StepDone   = 3'd7;

   typedef struct packed {
      op_type             op;
      logic [PcWidth-1:0] jmp;
      logic [PcWidth-1:0] nxt;
   } ctrl_word_type;

   function automatic ctrl_word_type microcode(input logic [PcWidth-1:0] pc);
      ctrl_word_type w;
      unique case (pc)
         StepIdle:   w = '{OP_IDLE,   StepLoad,  StepIdle};
         StepLoad:   w = '{OP_LOAD,   StepDone,  StepFit};
         StepFit:    w = '{OP_FIT,    StepYear,  StepZero};
         StepZero:   w = '{OP_ZERO,   StepMonth, StepSetlen};
         StepSetlen: w = '{OP_SETLEN, StepMonth, StepMonth};
         StepYear:   w = '{OP_YEAR,   StepYear,  StepMonth};
         StepMonth:  w = '{OP_MONTH,  StepMonth, StepDone};
         default:    w = '{OP_DONE,   StepIdle,  StepDone};
      endcase
      return w;
   endfunction

   function automatic logic is_leap(input logic [YearWidth-1:0] yy,
                                    input logic [CentWidth-1:0] cc);
      return (yy[1:0] == 2'b00) && ((yy != '0) || (cc[1:0] == 2'b00));
   endfunction

   function automatic logic [OrdWidth-1:0] year_len(input logic [YearWidth-1:0] yy,
                                                    input logic [CentWidth-1:0] cc);
      return is_leap(yy, cc) ? LeapLen : PlainLen;
   endfunction

   function automatic logic [OrdWidth-1:0] days_before(input logic [MonthWidth-1:0] m);
      logic [OrdWidth-1:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [DayWidth:0] month_len(input logic [MonthWidth-1:0] m,
                                                   input logic leap);
      logic [DayWidth:0] d;
      unique case (m)
         4'd2:                      d = leap ? 6'd29 : 6'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   d = 6'd30;
         default:                   d = 6'd31;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/calendar_date_add_days.sv
// Top level of the date adder: a microcoded sequencer over a small date datapath.
// An empty date goes from load straight to done; otherwise the sequencer fits the offset
// into the current year, then walks whole years and months until the date is reached.
// Throughput: one item at a time; the next item is taken at the edge after its result
// enters the output register, which holds it until the result side takes it.
// Synchronous active-high reset clears the sequencer and output valid; offset 7168.
`default_nettype none
module calendar_date_add_days
   import cdad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // in_day[4:0], in_month[8:5], in_year[15:9]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_day[4:0], out_month[8:5], out_year[15:9]
   output logic [0:0]       rsp_tuser    // date_empty[0]
);

   logic [AddWidth-1:0]   days_ff;
   logic [PcWidth-1:0]    pc_ff, pc_in;
   logic [DayWidth-1:0]   day_ff, day_in;
   logic [MonthWidth-1:0] mon_ff, mon_in;
   logic [YearWidth-1:0]  yy_ff, yy_in;
   logic [CentWidth-1:0]  cc_ff, cc_in;
   logic                  empty_ff, empty_in;
   logic [OrdWidth-1:0]   ord_ff, ord_in;
   logic [AddWidth-1:0]   left_ff, left_in;
   logic [MonthWidth-1:0] m_ff, m_in;
   logic                  rvalid_ff, rvalid_in;
   logic [15:0]           rdata_ff, rdata_in;
   logic                  rempty_ff, rempty_in;

   ctrl_word_type         cw;
   logic                  cond;
   logic                  leap;
   logic [OrdWidth-1:0]   ylen;
   logic [OrdWidth-1:0]   rem;
   logic [DayWidth:0]     mlen;
   logic [YearWidth-1:0]  yy_inc, yy_dec;
   logic [CentWidth-1:0]  cc_inc, cc_dec;
   logic [MonthWidth-1:0] req_mon;
   logic [YearWidth-1:0]  req_yy;

   assign csr_ready  = 1'b1;
   assign req_tready = (pc_ff == StepIdle);
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = rempty_ff;

   assign cw   = microcode(pc_ff);
   assign leap = is_leap(yy_ff, cc_ff);
   assign ylen = year_len(yy_ff, cc_ff);
   assign rem  = ylen - ord_ff;
   assign mlen = month_len(m_ff, leap);

   assign yy_inc = (yy_ff == LastYy) ? '0 : yy_ff + 7'd1;
   assign cc_inc = (yy_ff == LastYy) ? cc_ff + 5'd1 : cc_ff;
   assign yy_dec = (yy_ff == '0) ? LastYy : yy_ff - 7'd1;
   assign cc_dec = (yy_ff == '0) ? cc_ff - 5'd1 : cc_ff;

   assign req_mon = req_tdata[8:5];
   assign req_yy  = req_tdata[15:9];

   always_comb begin
      cond      = 1'b0;
      day_in    = day_ff;
      mon_in    = mon_ff;
      yy_in     = yy_ff;
      cc_in     = cc_ff;
      empty_in  = empty_ff;
      ord_in    = ord_ff;
      left_in   = left_ff;
      m_in      = m_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rdata_in  = rdata_ff;
      rempty_in = rempty_ff;
      unique case (cw.op)
         OP_IDLE: begin
            cond     = req_tvalid;
            day_in   = req_tdata[4:0];
            mon_in   = (req_mon > LastMonth) ? LastMonth : req_mon;
            empty_in = (req_mon == '0);
            m_in     = 4'd1;
            if (req_yy == LastYy) begin
               yy_in = LastYy;
               cc_in = Cent19;
            end else if (req_yy >= YyWrap) begin
               yy_in = req_yy - YyWrap;
               cc_in = Cent21;
            end else begin
               yy_in = req_yy;
               cc_in = Cent20;
            end
         end
         OP_LOAD: begin
            cond    = empty_ff;
            left_in = days_ff;
            ord_in  = days_before(mon_ff) + {4'd0, day_ff}
                    + {8'd0, (mon_ff > February) && leap};
         end
         OP_FIT: begin
            cond = (left_ff > {7'd0, rem});
            if (cond) begin
               left_in = left_ff - {7'd0, rem};
               yy_in   = yy_inc;
               cc_in   = cc_inc;
            end else begin
               ord_in = ord_ff + left_ff[OrdWidth-1:0];
            end
         end
         OP_ZERO: begin
            cond = (ord_ff != '0);
            if (!cond) begin
               yy_in = yy_dec;
               cc_in = cc_dec;
            end
         end
         OP_SETLEN: begin
            ord_in = ylen;
         end
         OP_YEAR: begin
            cond = (left_ff > {7'd0, ylen});
            if (cond) begin
               left_in = left_ff - {7'd0, ylen};
               yy_in   = yy_inc;
               cc_in   = cc_inc;
            end else begin
               ord_in = left_ff[OrdWidth-1:0];
            end
         end
         OP_MONTH: begin
            cond = (m_ff < LastMonth) && (ord_ff > {3'd0, mlen});
            if (cond) begin
               ord_in = ord_ff - {3'd0, mlen};
               m_in   = m_ff + 4'd1;
            end
         end
         OP_DONE: begin
            cond = !rvalid_ff || rsp_tready;
            if (cond) begin
               rvalid_in = 1'b1;
               rempty_in = empty_ff;
               rdata_in  = empty_ff ? '0 : {yy_ff, m_ff, ord_ff[DayWidth-1:0]};
            end
         end
         default: begin
            cond = 1'b0;
         end
      endcase
      pc_in = cond ? cw.jmp : cw.nxt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_ff   <= DefaultDays;
         pc_ff     <= StepIdle;
         rvalid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            days_ff <= csr_data;
         end
         pc_ff     <= pc_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      day_ff    <= day_in;
      mon_ff    <= mon_in;
      yy_ff     <= yy_in;
      cc_ff     <= cc_in;
      empty_ff  <= empty_in;
      ord_ff    <= ord_in;
      left_ff   <= left_in;
      m_ff      <= m_in;
      rdata_ff  <= rdata_in;
      rempty_ff <= rempty_in;
   end

endmodule
`default_nettype wire

>>> rtl/core/cdad_checker.sv
// Port-level checker for the date adder, bound to the top level.
`default_nettype none
module cdad_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input side ready again straight after an item was taken");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("empty date item carries a non-zero date");

   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
         rsp_tdata[4:0] != 5'd0 && rsp_tdata[8:5] != 4'd0 && rsp_tdata[8:5] <= 4'd12
         && rsp_tdata[15:9] <= 7'd99)
      else $error("result item holds an impossible date");

endmodule

bind calendar_date_add_days cdad_checker u_cdad_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
